// ----- rtl/core/auto_range_linear_scaler_macros.svh -----
// Assertion macros shared by the scaler checkers.
// No dependencies; included by the checker file.
`ifndef AUTO_RANGE_LINEAR_SCALER_MACROS_SVH
`define AUTO_RANGE_LINEAR_SCALER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ARLS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ARLS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/core/arls_pkg.sv -----
// Types, codes and helpers for the auto-ranging linear scaler.
// No dependencies; used by the scaler, divider, checker and testbench files.
package arls_pkg;

	localparam int FRAC_BITS = 16;
	localparam int CFG_IDX_W = 1;

	localparam logic [31:0] FX_ONE = 32'd1 << FRAC_BITS;

	// request codes
	localparam logic [1:0] REQ_SAMPLE = 2'd0;
	localparam logic [1:0] REQ_CLEAR  = 2'd1;
	localparam logic [1:0] REQ_PRESET = 2'd2;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_OUT_FIRST  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_OUT_SECOND = 1'b1;

	typedef struct packed {
		logic [1:0]         req_type;
		logic signed [31:0] sample;
		logic signed [31:0] preset_min;
		logic signed [31:0] preset_max;
	} in_item_t;

	typedef struct packed {
		logic               scaled_valid;
		logic signed [31:0] scaled;
		logic signed [31:0] range_low;
		logic signed [31:0] range_high;
		logic [31:0]        factor_in;
		logic [31:0]        factor_out;
	} out_item_t;

	typedef struct packed {
		logic        start;
		logic [63:0] num;
		logic [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic        done;
		logic [31:0] quot;
	} div_rsp_t;

	// |a - b| of two signed 32-bit values; always fits 32 unsigned bits
	function automatic logic [31:0] abs_diff(input logic signed [31:0] a,
			input logic signed [31:0] b);
		logic signed [32:0] d;
		logic [32:0]        nd;
		d  = 33'(a) - 33'(b);
		nd = -d;
		return d[32] ? nd[31:0] : d[31:0];
	endfunction

endpackage

// ----- rtl/core/arls_chan_if.sv -----
// Valid/ready channel carrying one payload beat.
// Payload type is set per instance (arls_pkg item structs).
interface arls_chan_if #(parameter type payload_t = logic);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ----- rtl/core/auto_range_linear_scaler.sv -----
// Auto-ranging linear scaler: tracked range, sequencer and output register.
// Depends on arls_pkg, arls_chan_if and arls_div.
//
// Usage:
//   samples : request beats (req_type, sample, preset_min, preset_max).
//             Sample requests are scaled, clear zeroes the tracked range,
//             preset loads it. Ready is high only while the sequencer idles.
//   results : one beat per request with the mapped sample, sorted range and
//             both scale factors. Held in an output register.
//   cfg_*   : write port for out_first_end (index 0) and out_second_end
//             (index 1); write only while no request is in flight.
// Steps: range, multiply, then for a sample with a nonzero input range a
//   divider launch and pass, factor setup, a second divider pass when both
//   ranges are nonzero, and one output load. The shared divider serves one
//   request at a time; the next is accepted only once the sequencer idles.
// Reset clears the tracked range, the seeded flag, the output valid flag and
//   loads the output range 0.0 .. 1.0.
// Back-pressure: a finished result waits in the sequencer's last step until
//   the output register is free; a waiting result does not block acceptance
//   of the next request once it has moved into the output register.
module auto_range_linear_scaler import arls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	arls_chan_if.sink            samples,
	arls_chan_if.source          results,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_RANGE = 3'd1;
	localparam logic [2:0] S_MUL   = 3'd2;
	localparam logic [2:0] S_Q1GO  = 3'd3;
	localparam logic [2:0] S_Q1W   = 3'd4;
	localparam logic [2:0] S_FAC   = 3'd5;
	localparam logic [2:0] S_Q2W   = 3'd6;
	localparam logic [2:0] S_DONE  = 3'd7;

	logic [2:0] state_q;

	// configuration and tracked state
	logic signed [31:0] first_q, second_q;
	logic signed [31:0] min_q, max_q;
	logic               seeded_q;

	// per-request working registers
	logic [1:0]         req_q;
	logic signed [31:0] smp_q;
	logic [31:0]        rin_q, rout_q, dmag_q;
	logic               le_q;   // first end <= second end
	logic [63:0]        prod_q;
	logic signed [31:0] scaled_q;
	logic [31:0]        fin_q, fout_q;

	logic      out_valid_q;
	out_item_t out_q;

	div_req_t div_req;
	div_rsp_t div_rsp;

	logic               accept;
	logic               out_free;
	logic signed [31:0] base;
	logic               rin_le;
	logic               need_div;
	logic [63:0]        fac_num;
	logic [31:0]        fac_den;
	logic signed [33:0] sum;
	logic signed [31:0] sum_sat;
	logic signed [31:0] lo, hi;
	logic signed [31:0] v_in;
	logic               seed_now;

	assign accept   = samples.valid && samples.ready;
	assign out_free = !out_valid_q || results.ready;

	always_comb begin
		v_in     = samples.payload.sample;
		seed_now = !seeded_q && (min_q == max_q);
		base     = le_q ? first_q : second_q;
		rin_le   = rin_q <= rout_q;
		need_div = (rin_q != 32'd0) && (rout_q != 32'd0);
		fac_num  = {32'd0, (rin_le ? rout_q : rin_q)} << FRAC_BITS;
		fac_den  = rin_le ? rin_q : rout_q;
		// base plus unsigned quotient; only the top can overflow
		sum      = 34'(base) + $signed({2'b00, div_rsp.quot});
		sum_sat  = (!sum[33] && sum[32:31] != 2'b00) ? 32'sh7FFF_FFFF : sum[31:0];
		if (min_q <= max_q) begin
			lo = min_q;
			hi = max_q;
		end else begin
			lo = max_q;
			hi = min_q;
		end
		// one divider, two uses: scaled sample then the factor
		div_req.start = (state_q == S_Q1GO) || ((state_q == S_FAC) && need_div);
		div_req.num   = (state_q == S_Q1GO) ? prod_q : fac_num;
		div_req.den   = (state_q == S_Q1GO) ? rin_q : fac_den;
	end

	arls_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	// output range registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= FX_ONE;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				REG_OUT_FIRST:  first_q  <= cfg_wdata;
				REG_OUT_SECOND: second_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// tracked range: updated in the accept cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q    <= '0;
			max_q    <= '0;
			seeded_q <= 1'b0;
		end else if (accept) begin
			priority case (samples.payload.req_type)
				REQ_CLEAR: begin
					min_q    <= '0;
					max_q    <= '0;
					seeded_q <= 1'b0;
				end
				REQ_PRESET: begin
					min_q <= samples.payload.preset_min;
					max_q <= samples.payload.preset_max;
				end
				REQ_SAMPLE: begin
					if (seed_now) begin
						// first sample after a clear loads both ends
						seeded_q <= 1'b1;
						min_q    <= v_in;
						max_q    <= v_in;
					end else begin
						if (v_in < min_q) min_q <= v_in;
						if (v_in > max_q) max_q <= v_in;
					end
				end
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE:  if (accept) state_q <= S_RANGE;
				S_RANGE: state_q <= S_MUL;
				S_MUL: begin
					if (req_q == REQ_SAMPLE && rin_q != 32'd0) state_q <= S_Q1GO;
					else state_q <= S_FAC;
				end
				S_Q1GO:  state_q <= S_Q1W;
				S_Q1W:   if (div_rsp.done) state_q <= S_FAC;
				S_FAC:   state_q <= need_div ? S_Q2W : S_DONE;
				S_Q2W:   if (div_rsp.done) state_q <= S_DONE;
				S_DONE:  if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					req_q <= samples.payload.req_type;
					smp_q <= v_in;
				end
			end
			S_RANGE: begin
				le_q   <= first_q <= second_q;
				rin_q  <= abs_diff(max_q, min_q);
				rout_q <= abs_diff(second_q, first_q);
				dmag_q <= (first_q <= second_q) ? abs_diff(smp_q, min_q)
					: abs_diff(smp_q, max_q);
			end
			S_MUL: begin
				prod_q   <= 64'(dmag_q) * 64'(rout_q);
				// zero input range maps to the lower output end
				scaled_q <= (req_q == REQ_SAMPLE) ? base : 32'sd0;
			end
			S_Q1GO: ;
			S_Q1W: begin
				if (div_rsp.done) scaled_q <= sum_sat;
			end
			S_FAC: begin
				priority if (rin_q == 32'd0) begin
					fin_q  <= '0;
					fout_q <= rout_q;
				end else if (rout_q == 32'd0) begin
					fin_q  <= rin_q;
					fout_q <= '0;
				end else if (rin_le) begin
					fin_q <= FX_ONE;
				end else begin
					fout_q <= FX_ONE;
				end
			end
			S_Q2W: begin
				if (div_rsp.done) begin
					if (rin_le) fout_q <= div_rsp.quot;
					else fin_q <= div_rsp.quot;
				end
			end
			S_DONE: ;
			default: ;
		endcase
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (results.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_q.scaled_valid <= req_q == REQ_SAMPLE;
			out_q.scaled       <= scaled_q;
			out_q.range_low    <= lo;
			out_q.range_high   <= hi;
			out_q.factor_in    <= fin_q;
			out_q.factor_out   <= fout_q;
		end
	end

	assign samples.ready   = state_q == S_IDLE;
	assign results.valid   = out_valid_q;
	assign results.payload = out_q;

endmodule

// ----- rtl/core/arls_div.sv -----
// Shared restoring divider: 64-bit dividend / 32-bit divisor, one bit per cycle.
// Quotient saturates at 2^32-1. Depends on arls_pkg.
module arls_div import arls_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic        busy_q;
	logic        done_q;
	logic [4:0]  cnt_q;
	logic [31:0] rem_q;
	logic [31:0] quo_q;
	logic [31:0] den_q;

	logic [32:0] shifted;
	logic [33:0] trial;
	logic        ge;
	logic        sat;

	always_comb begin
		shifted = {rem_q, quo_q[31]};
		trial   = {1'b0, shifted} - {2'b00, den_q};
		ge      = !trial[33];
		// quotient would need more than 32 bits (or divide by zero)
		sat     = (req.den == 32'd0) || (req.num[63:32] >= req.den);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= !sat;
			done_q <= sat;
			cnt_q  <= 5'd31;
		end else if (busy_q) begin
			if (cnt_q == 5'd0) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end else begin
				cnt_q <= cnt_q - 5'd1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.num[63:32];
			quo_q <= sat ? 32'hFFFF_FFFF : req.num[31:0];
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= ge ? trial[31:0] : shifted[31:0];
			quo_q <= {quo_q[30:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = quo_q;

endmodule

// ----- rtl/core/arls_chk.sv -----
// Port-level checker for the scaler, bound to the top level.
// Depends on arls_pkg and auto_range_linear_scaler_macros.svh.
`include "auto_range_linear_scaler_macros.svh"

module arls_chk import arls_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      in_valid,
	input logic      in_ready,
	input logic      out_valid,
	input logic      out_ready,
	input out_item_t out_payload
);

	// one request at a time: no accept in the cycle after an accept
	`ARLS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, in_valid && in_ready, !in_ready,
		"accepted a beat while a request was in flight")

	// stalled result beat holds
	`ARLS_ASSERT_NXT(a_out_hold, clk, arst_n, out_valid && !out_ready,
		out_valid && $stable(out_payload), "result beat changed under stall")

	`ARLS_ASSERT_NOW(a_range_sorted, clk, arst_n, out_valid,
		out_payload.range_low <= out_payload.range_high, "range not sorted")

	`ARLS_ASSERT_NOW(a_scaled_zero, clk, arst_n, out_valid && !out_payload.scaled_valid,
		out_payload.scaled == 32'sd0, "scaled nonzero on non-sample beat")

	// zero input range reports a zero input factor
	`ARLS_ASSERT_NOW(a_zero_range_fin, clk, arst_n,
		out_valid && (out_payload.range_low == out_payload.range_high),
		out_payload.factor_in == 32'd0, "factor_in nonzero on empty range")

endmodule

bind auto_range_linear_scaler arls_chk u_arls_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_valid    (samples.valid),
	.in_ready    (samples.ready),
	.out_valid   (results.valid),
	.out_ready   (results.ready),
	.out_payload (results.payload)
);

// ----- tb/sv/arls_result_check.sv -----
// Result checker for the auto-ranging linear scaler: predicts each result beat
// from the accepted request beats and register writes, and compares it. Uses arls_pkg.
`timescale 1ns / 100ps

module arls_result_check import arls_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	input  logic                 in_ready,
	input  in_item_t             in_beat,
	input  logic                 out_valid,
	input  logic                 out_ready,
	input  out_item_t            out_beat,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_idx,
	input  logic [31:0]          cfg_wdata,
	output int                   outstanding,
	output int                   fail_count
);

	logic signed [31:0] first_end, second_end;
	longint             trk_min, trk_max;
	bit                 seeded;
	out_item_t          pending_results[$];

	function automatic logic [63:0] mag64(input longint x);
		return (x < 0) ? -x : x;
	endfunction

	// truncating divide, saturated to 32 bits (divide by zero gives all ones)
	function automatic logic [31:0] quot_sat(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		if (den == 0)
			return '1;
		q = num / den;
		return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
	endfunction

	// updates the tracked range and returns the result of one request beat
	function automatic out_item_t scale_item(input in_item_t it);
		out_item_t   r;
		longint      smp, d, base, sum;
		logic [63:0] rin, rout;
		logic [31:0] q;
		r = '0;
		if (it.req_type == REQ_CLEAR) begin
			trk_min = 0;
			trk_max = 0;
			seeded  = 1'b0;
		end else if (it.req_type == REQ_PRESET) begin
			trk_min = longint'(it.preset_min);
			trk_max = longint'(it.preset_max);
		end
		rout = mag64(longint'(second_end) - longint'(first_end));
		if (it.req_type == REQ_SAMPLE) begin
			smp = longint'(it.sample);
			if (!seeded && trk_min == trk_max) begin
				seeded  = 1'b1;
				trk_min = smp;
				trk_max = smp;
			end
			if (smp < trk_min)
				trk_min = smp;
			if (smp > trk_max)
				trk_max = smp;
			rin = mag64(trk_max - trk_min);
			r.scaled_valid = 1'b1;
			if (rin == 0) begin
				r.scaled = (first_end <= second_end) ? first_end : second_end;
			end else begin
				if (first_end <= second_end) begin
					d    = smp - trk_min;
					base = first_end;
				end else begin
					d    = smp - trk_max;
					base = second_end;
				end
				q   = quot_sat(mag64(d) * rout, rin);
				sum = base + longint'({32'd0, q});
				if (sum > 64'sd2147483647)
					sum = 64'sd2147483647;
				if (sum < -64'sd2147483648)
					sum = -64'sd2147483648;
				r.scaled = sum[31:0];
			end
		end
		rin = mag64(trk_max - trk_min);
		if (rin == 0) begin
			r.factor_in  = '0;
			r.factor_out = rout[31:0];
		end else if (rout == 0) begin
			r.factor_in  = rin[31:0];
			r.factor_out = '0;
		end else if (rin <= rout) begin
			r.factor_in  = FX_ONE;
			r.factor_out = quot_sat(rout << FRAC_BITS, rin);
		end else begin
			r.factor_in  = quot_sat(rin << FRAC_BITS, rout);
			r.factor_out = FX_ONE;
		end
		r.range_low  = (trk_min <= trk_max) ? trk_min[31:0] : trk_max[31:0];
		r.range_high = (trk_min <= trk_max) ? trk_max[31:0] : trk_min[31:0];
		return r;
	endfunction

	function automatic bit field_bad(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			return 1'b1;
		end
		return 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		out_item_t want;
		bit        bad;
		if (!arst_n) begin
			first_end  = '0;
			second_end = FX_ONE;
			trk_min    = 0;
			trk_max    = 0;
			seeded     = 1'b0;
			pending_results.delete();
			outstanding <= 0;
			fail_count  <= 0;
		end else begin
			// result side first: a beat accepted now can't belong to a request of this edge
			if (out_valid && out_ready) begin
				if (pending_results.size() == 0) begin
					$display("%0t: result beat with nothing pending, expected none, actual %p",
						$time, out_beat);
					fail_count <= fail_count + 1;
				end else begin
					want = pending_results.pop_front();
					bad  = field_bad("scaled_valid", {31'd0, want.scaled_valid},
							{31'd0, out_beat.scaled_valid})
						| field_bad("scaled", want.scaled, out_beat.scaled)
						| field_bad("range_low", want.range_low, out_beat.range_low)
						| field_bad("range_high", want.range_high, out_beat.range_high)
						| field_bad("factor_in", want.factor_in, out_beat.factor_in)
						| field_bad("factor_out", want.factor_out, out_beat.factor_out);
					if (bad)
						fail_count <= fail_count + 1;
				end
			end
			if (cfg_wen) begin
				case (cfg_idx)
					REG_OUT_FIRST:  first_end  = cfg_wdata;
					REG_OUT_SECOND: second_end = cfg_wdata;
					default: ;
				endcase
			end
			if (in_valid && in_ready)
				pending_results.push_back(scale_item(in_beat));
			outstanding <= pending_results.size();
		end
	end

endmodule

// ----- tb/sv/auto_range_linear_scaler_test.sv -----
// Top of the scaler testbench: clock, reset, request and register stimulus, verdict.
// Depends on arls_pkg, arls_chan_if, auto_range_linear_scaler and arls_result_check.
`timescale 1ns / 100ps

module auto_range_linear_scaler_test;
	import arls_pkg::*;

	// request code the block must ignore (no name in the package)
	localparam logic [1:0] REQ_UNKNOWN = 2'd3;

	// Run bound for ~780 requests with worst-case divides, sender gaps and
	// receiver stalls, with a wide margin.
	localparam int CYCLE_LIMIT = 500_000;

	// cycles to sit after the last result, longer than one full divide request
	localparam int TAIL_CYCLES = 100;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_wen;
	logic [CFG_IDX_W-1:0] cfg_idx;
	logic [31:0]          cfg_wdata;
	bit                   throttle;
	int                   outstanding;
	int                   fail_count;
	int                   cycles = 0;

	arls_chan_if #(.payload_t(in_item_t))  req_ch ();
	arls_chan_if #(.payload_t(out_item_t)) res_ch ();

	auto_range_linear_scaler u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.samples   (req_ch),
		.results   (res_ch),
		.cfg_wen   (cfg_wen),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	arls_result_check u_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (req_ch.valid),
		.in_ready    (req_ch.ready),
		.in_beat     (req_ch.payload),
		.out_valid   (res_ch.valid),
		.out_ready   (res_ch.ready),
		.out_beat    (res_ch.payload),
		.cfg_wen     (cfg_wen),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.outstanding (outstanding),
		.fail_count  (fail_count)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Runaway guard: any hang in the handshakes ends here.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// Result side: stalls about a third of the cycles while throttled,
	// always ready otherwise.
	always @(posedge clk)
		res_ch.ready <= !throttle || ($urandom_range(99) >= 34);

	// Q16.16 constant from a whole number
	function automatic logic [31:0] fx(input int whole);
		return 32'(whole <<< FRAC_BITS);
	endfunction

	// Field value: extremes, zero, small values near zero (so the tracked
	// range stays narrow for a while) and full-width noise.
	function automatic logic [31:0] rand_word();
		logic [31:0] w;
		w = $urandom;
		case ($urandom_range(15))
			0: return 32'h7FFF_FFFF;
			1: return 32'h8000_0000;
			2: return '0;
			3, 4, 5, 6, 7, 8, 9: return {{12{w[19]}}, w[19:0]};
			default: return w;
		endcase
	endfunction

	// One request beat. Returns in the time step of the accepting edge with
	// valid still high, so the next call either re-drives valid high with a
	// new payload or drops it, one assignment per step either way.
	task automatic send_beat(input logic [1:0] req, input logic [31:0] smp,
			input logic [31:0] pmin, input logic [31:0] pmax);
		while (throttle && $urandom_range(99) < 34) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid              <= 1'b1;
		req_ch.payload.req_type   <= req;
		req_ch.payload.sample     <= smp;
		req_ch.payload.preset_min <= pmin;
		req_ch.payload.preset_max <= pmax;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	// Stop sending and wait for every predicted result to come back.
	// The checker's count is registered, hence the wait before the first look.
	task automatic drain_results();
		req_ch.valid <= 1'b0;
		do
			@(posedge clk);
		while (outstanding != 0);
	endtask

	// Registers are only touched with the block idle; both are written
	// on consecutive edges with the enable held high across them.
	task automatic set_out_range(input logic [31:0] first_val, input logic [31:0] second_val);
		drain_results();
		cfg_wen   <= 1'b1;
		cfg_idx   <= REG_OUT_FIRST;
		cfg_wdata <= first_val;
		@(posedge clk);
		cfg_idx   <= REG_OUT_SECOND;
		cfg_wdata <= second_val;
		@(posedge clk);
		cfg_wen   <= 1'b0;
	endtask

	initial begin : stimulus
		int unsigned pick;
		logic [31:0] w;
		logic [1:0]  req;

		arst_n         = 1'b0;
		throttle       = 1'b1;
		cfg_wen        = 1'b0;
		cfg_idx        = REG_OUT_FIRST;
		cfg_wdata      = '0;
		req_ch.valid   = 1'b0;
		req_ch.payload = '0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, output range at its reset value 0.0 .. 1.0 ---
		send_beat(REQ_SAMPLE, fx(5), '0, '0);              // first sample seeds both ends
		send_beat(REQ_SAMPLE, fx(7), '0, '0);              // widen upward
		send_beat(REQ_SAMPLE, fx(6), '0, '0);              // inside the range
		send_beat(REQ_SAMPLE, 32'h7FFF_FFFF, '0, '0);      // largest sample
		send_beat(REQ_SAMPLE, 32'h8000_0000, '0, '0);      // smallest: full input range
		send_beat(REQ_SAMPLE, '0, '0, '0);
		send_beat(REQ_UNKNOWN, $urandom, $urandom, $urandom); // ignored request
		send_beat(REQ_CLEAR, $urandom, $urandom, $urandom);
		// one-LSB input range: output factor saturates
		send_beat(REQ_PRESET, '0, '0, 32'd1);
		send_beat(REQ_SAMPLE, '0, '0, '0);
		// preset with min above max is kept as loaded
		send_beat(REQ_PRESET, '0, fx(10), fx(-3));
		send_beat(REQ_SAMPLE, fx(1), '0, '0);
		send_beat(REQ_SAMPLE, fx(20), '0, '0);
		// equal preset while not seeded: next sample reseeds
		send_beat(REQ_CLEAR, '0, '0, '0);
		send_beat(REQ_PRESET, '0, fx(2), fx(2));
		send_beat(REQ_SAMPLE, fx(4), '0, '0);
		send_beat(REQ_SAMPLE, 32'h8000_0000, '0, '0);      // input range far above output

		// widest reversed output range: inverted mapping
		set_out_range(32'h7FFF_FFFF, 32'h8000_0000);
		send_beat(REQ_SAMPLE, '0, '0, '0);
		send_beat(REQ_SAMPLE, 32'h7FFF_FFFF, '0, '0);
		send_beat(REQ_PRESET, '0, fx(-8), fx(8));
		send_beat(REQ_SAMPLE, fx(-2), '0, '0);

		// zero output range
		set_out_range(fx(3), fx(3));
		send_beat(REQ_SAMPLE, fx(-1), '0, '0);
		send_beat(REQ_PRESET, '0, fx(-5), fx(9));
		send_beat(REQ_SAMPLE, fx(2), '0, '0);

		// --- random part: five phases of 150 beats, one output range each ---
		for (int ph = 0; ph < 5; ph++) begin
			w = rand_word();
			case (ph)
				0: set_out_range(32'h8000_0000, 32'h7FFF_FFFF);
				1: set_out_range(32'h7FFF_FFFF, 32'h8000_0000);
				2: set_out_range($urandom, $urandom);
				3: set_out_range(w, w);
				default: set_out_range(rand_word(), rand_word());
			endcase
			// phase 2 runs with no gaps and no stalls at all
			throttle <= (ph != 2);
			for (int n = 0; n < 150; n++) begin
				// mostly samples; clears now and then restart the tracking
				pick = $urandom_range(99);
				if (pick < 80)
					req = REQ_SAMPLE;
				else if (pick < 86)
					req = REQ_CLEAR;
				else if (pick < 96)
					req = REQ_PRESET;
				else
					req = REQ_UNKNOWN;
				send_beat(req, rand_word(), rand_word(), rand_word());
			end
		end

		drain_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fail_count == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
